[rtl/bfp_pkg.sv]
// Shared types, constants and tables for the biped foot placement core.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package bfp_pkg;

  // Parameter defaults and limits
  localparam int unsigned DefNumLegs     = 2;
  localparam int unsigned DefCordicSteps = 16;
  localparam int unsigned MaxCordicSteps = 24;

  // Internal widths
  localparam int unsigned SumW = 52;  // step and angle sums
  localparam int unsigned PosW = 53;  // position plus step offset
  localparam int unsigned VecW = 64;  // CORDIC vector, Q2.30 scaled
  localparam int unsigned AngW = 34;  // CORDIC angle, Q2.30

  // Register reset values (0.1 and 0.01 in Q16.16)
  localparam logic [31:0] GainXyRst  = 32'd6554;
  localparam logic [31:0] GainYawRst = 32'd655;

  // Gait phase: one in Q1.16
  localparam logic [16:0] OneQ16 = 17'd65536;

  // Angle constants
  localparam logic [18:0] TwoPiQ16 = 19'd411775;
  localparam logic [17:0] PiQ16    = 18'd205887;
  localparam logic signed [AngW-1:0] PiQ30     = AngW'(64'sd3373259426);
  localparam logic signed [AngW-1:0] HalfPiQ30 = AngW'(64'sd1686629713);
  localparam logic signed [31:0]     InvGain   = 32'sd652032875;

  // 2^34 mod 2*pi and reciprocal 2^38 / 2*pi for the angle reduction
  localparam logic [18:0] Fold34 = 19'((64'd1 << 34) % 64'd411775);
  localparam logic [19:0] Recip  = 20'((64'd1 << 38) / 64'd411775);

  // arctan(2^-i) in Q2.30
  localparam logic [29:0] AtanQ30 [MaxCordicSteps] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
    30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
    30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
    30'd262144,    30'd131072,    30'd65536,     30'd32768,
    30'd16384,     30'd8192,      30'd4096,      30'd2048,
    30'd1024,      30'd512,       30'd256,       30'd128
  };

  // Register indexes; legs follow on from CfgLeg0
  typedef enum logic [2:0] {
    CfgSwing   = 3'd0,
    CfgStance  = 3'd1,
    CfgGainX   = 3'd2,
    CfgGainY   = 3'd3,
    CfgGainYaw = 3'd4,
    CfgLeg0    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] swing_time;
    logic [31:0] stance_time;
    logic [31:0] gain_x;
    logic [31:0] gain_y;
    logic [31:0] gain_yaw;
  } cfg_t;

  typedef struct packed {
    logic               leg_index;
    logic signed [31:0] goal_vel_x;
    logic signed [31:0] goal_vel_y;
    logic signed [31:0] goal_yaw_rate;
    logic [16:0]        gait_phase;
    logic signed [31:0] body_vel_x;
    logic signed [31:0] body_vel_y;
    logic signed [31:0] body_yaw;
    logic signed [31:0] body_yaw_rate;
    logic signed [31:0] body_pos_x;
    logic signed [31:0] body_pos_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] foot_x;
    logic signed [31:0] foot_y;
  } out_item_t;

  // Vector to rotate plus the position sums that ride along
  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [PosW-1:0] cx;
    logic signed [PosW-1:0] cy;
  } vec_t;

  typedef struct packed {
    logic signed [SumW-1:0] ang_sum;
    vec_t                   vec;
  } step_t;

  typedef struct packed {
    logic signed [AngW-1:0] z;
    vec_t                   vec;
  } rot_t;

endpackage

[rtl/biped_foot_placement_core.sv]
// Top level of the biped foot placement core: registers, pipeline, output.
// Depends on bfp_pkg, bfp_step, bfp_angle and bfp_cordic.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------
//  in      | into core | in_valid_i / in_stall_o | in_data_i (in_item_t)
//  out     | from core | out_valid_o / out_stall_i | out_data_o (out_item_t)
//  cfg     | into core | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// One transaction per cycle while in_stall_o is low; each result passes the
// bfp_step, bfp_angle and bfp_cordic stages and then the output register.
// All stages advance together; a skid register behind the output register
// takes one result while out is stalled, and only a full skid stalls the input.
// rst_ni clears valid bits and registers to their reset values.
`timescale 1ns / 1ps

module biped_foot_placement_core #(
  parameter int unsigned NUM_LEGS     = bfp_pkg::DefNumLegs,
  parameter int unsigned CORDIC_STEPS = bfp_pkg::DefCordicSteps
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bfp_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bfp_pkg::out_item_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [63:0]        cfg_data_i
);
  import bfp_pkg::*;

  cfg_t        cfg_q;
  logic [63:0] leg_off_q [NUM_LEGS];
  logic [63:0] leg_off_c;

  logic  en;
  logic  step_v, ang_v, cor_v;
  step_t step_d;
  rot_t  ang_d;
  vec_t  cor_d;

  logic signed [53:0] sum_x_c, sum_y_c;
  out_item_t res_c;
  out_item_t out_q, skid_q;
  logic      out_v_q, skid_v_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.swing_time  <= '0;
      cfg_q.stance_time <= '0;
      cfg_q.gain_x      <= GainXyRst;
      cfg_q.gain_y      <= GainXyRst;
      cfg_q.gain_yaw    <= GainYawRst;
      for (int i = 0; i < NUM_LEGS; i++) begin
        leg_off_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSwing:   cfg_q.swing_time  <= cfg_data_i[31:0];
        CfgStance:  cfg_q.stance_time <= cfg_data_i[31:0];
        CfgGainX:   cfg_q.gain_x      <= cfg_data_i[31:0];
        CfgGainY:   cfg_q.gain_y      <= cfg_data_i[31:0];
        CfgGainYaw: cfg_q.gain_yaw    <= cfg_data_i[31:0];
        default: ;
      endcase
      for (int i = 0; i < NUM_LEGS; i++) begin
        if (32'(cfg_idx_i) == 32'(CfgLeg0) + 32'(i)) begin
          leg_off_q[i] <= cfg_data_i;
        end
      end
    end
  end

  // Leg select; an index past the last leg uses the last leg
  always_comb begin
    leg_off_c = leg_off_q[NUM_LEGS-1];
    for (int i = 0; i < NUM_LEGS - 1; i++) begin
      if (32'(in_data_i.leg_index) == 32'(i)) begin
        leg_off_c = leg_off_q[i];
      end
    end
  end

  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  bfp_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_valid_i),
    .data_i    (in_data_i),
    .cfg_i     (cfg_q),
    .leg_off_i (leg_off_c),
    .valid_o   (step_v),
    .data_o    (step_d)
  );

  bfp_angle u_angle (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (step_v),
    .data_i  (step_d),
    .valid_o (ang_v),
    .data_o  (ang_d)
  );

  bfp_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ang_v),
    .data_i  (ang_d),
    .valid_o (cor_v),
    .data_o  (cor_d)
  );

  // Final sum and saturation
  always_comb begin
    sum_x_c = 54'(cor_d.cx) + 54'(cor_d.x >>> 30);
    sum_y_c = 54'(cor_d.cy) + 54'(cor_d.y >>> 30);
    if (sum_x_c > 54'sd2147483647) begin
      res_c.foot_x = 32'sh7fffffff;
    end else if (sum_x_c < -54'sd2147483648) begin
      res_c.foot_x = 32'sh80000000;
    end else begin
      res_c.foot_x = 32'(sum_x_c);
    end
    if (sum_y_c > 54'sd2147483647) begin
      res_c.foot_y = 32'sh7fffffff;
    end else if (sum_y_c < -54'sd2147483648) begin
      res_c.foot_y = 32'sh80000000;
    end else begin
      res_c.foot_y = 32'(sum_y_c);
    end
  end

  // Output register with skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || !out_stall_i) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= cor_v;
      end
    end else if (en && cor_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || !out_stall_i) begin
      out_q <= skid_v_q ? skid_q : res_c;
    end else if (en && cor_v) begin
      skid_q <= res_c;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

[rtl/bfp_step.sv]
// Step offset and yaw lead: three register stages of products and sums.
// Depends on bfp_pkg.
`timescale 1ns / 1ps

module bfp_step (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  bfp_pkg::in_item_t data_i,
  input  bfp_pkg::cfg_t    cfg_i,
  input  logic [63:0]      leg_off_i,
  output logic             valid_o,
  output bfp_pkg::step_t   data_o
);
  import bfp_pkg::*;

  localparam int unsigned Lanes = 3;  // x, y, yaw

  logic [16:0] ph_c, om_c;
  logic signed [31:0] vel_c  [Lanes];
  logic signed [32:0] err_c  [Lanes];
  logic [31:0]        gain_c [Lanes];
  logic signed [49:0] p_om_c [Lanes];
  logic signed [65:0] p_st_c [Lanes];
  logic signed [65:0] p_g_c  [Lanes];
  logic signed [65:0] p_m_c  [Lanes];

  logic [2:0] v_q;

  // Stage 1 registers
  logic signed [32:0]     s1_a_q  [Lanes];
  logic signed [47:0]     s1_st_q [Lanes];
  logic signed [49:0]     s1_g_q  [Lanes];
  logic signed [31:0]     s1_yaw_q, s1_px_q, s1_py_q;
  logic signed [VecW-1:0] s1_x_q, s1_y_q;

  // Stage 2 registers
  logic signed [49:0]     s2_m_q  [Lanes];
  logic signed [47:0]     s2_st_q [Lanes];
  logic signed [49:0]     s2_g_q  [Lanes];
  logic signed [31:0]     s2_yaw_q, s2_px_q, s2_py_q;
  logic signed [VecW-1:0] s2_x_q, s2_y_q;

  step_t s3_q;

  // Lane operands and first products
  always_comb begin
    ph_c = (data_i.gait_phase > OneQ16) ? OneQ16 : data_i.gait_phase;
    om_c = OneQ16 - ph_c;
    vel_c[0]  = data_i.body_vel_x;
    vel_c[1]  = data_i.body_vel_y;
    vel_c[2]  = data_i.body_yaw_rate;
    err_c[0]  = 33'(data_i.body_vel_x) - 33'(data_i.goal_vel_x);
    err_c[1]  = 33'(data_i.body_vel_y) - 33'(data_i.goal_vel_y);
    err_c[2]  = 33'(data_i.goal_yaw_rate) - 33'(data_i.body_yaw_rate);
    gain_c[0] = cfg_i.gain_x;
    gain_c[1] = cfg_i.gain_y;
    gain_c[2] = cfg_i.gain_yaw;
    for (int k = 0; k < Lanes; k++) begin
      p_om_c[k] = 50'(vel_c[k]) * 50'($signed({1'b0, om_c}));
      p_st_c[k] = 66'(vel_c[k]) * 66'($signed({1'b0, cfg_i.stance_time}));
      p_g_c[k]  = 66'(err_c[k]) * 66'($signed({1'b0, gain_c[k]}));
    end
  end

  // Swing term product
  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      p_m_c[k] = 66'(s1_a_q[k]) * 66'($signed({1'b0, cfg_i.swing_time}));
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  // Payload stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < Lanes; k++) begin
        s1_a_q[k]  <= 33'(p_om_c[k] >>> 16);
        s1_st_q[k] <= 48'(p_st_c[k] >>> 17);
        s1_g_q[k]  <= 50'(p_g_c[k] >>> 16);
        s2_m_q[k]  <= 50'(p_m_c[k] >>> 16);
        s2_st_q[k] <= s1_st_q[k];
        s2_g_q[k]  <= s1_g_q[k];
      end
      s1_yaw_q <= data_i.body_yaw;
      s1_px_q  <= data_i.body_pos_x;
      s1_py_q  <= data_i.body_pos_y;
      s1_x_q   <= VecW'($signed(leg_off_i[63:32])) * VecW'(InvGain);
      s1_y_q   <= VecW'($signed(leg_off_i[31:0])) * VecW'(InvGain);

      s2_yaw_q <= s1_yaw_q;
      s2_px_q  <= s1_px_q;
      s2_py_q  <= s1_py_q;
      s2_x_q   <= s1_x_q;
      s2_y_q   <= s1_y_q;

      s3_q.vec.x   <= s2_x_q;
      s3_q.vec.y   <= s2_y_q;
      s3_q.vec.cx  <= PosW'(s2_px_q) + PosW'(s2_m_q[0]) + PosW'(s2_st_q[0])
                      + PosW'(s2_g_q[0]);
      s3_q.vec.cy  <= PosW'(s2_py_q) + PosW'(s2_m_q[1]) + PosW'(s2_st_q[1])
                      + PosW'(s2_g_q[1]);
      s3_q.ang_sum <= SumW'(s2_yaw_q) + SumW'(s2_m_q[2]) + SumW'(s2_st_q[2])
                      + SumW'(s2_g_q[2]);
    end
  end

  assign valid_o = v_q[2];
  assign data_o  = s3_q;

endmodule

[rtl/bfp_angle.sv]
// Angle reduction modulo 2*pi and half-turn fold into the CORDIC range.
// Seven register stages; depends on bfp_pkg.
`timescale 1ns / 1ps

module bfp_angle (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  bfp_pkg::step_t data_i,
  output logic           valid_o,
  output bfp_pkg::rot_t  data_o
);
  import bfp_pkg::*;

  localparam int unsigned Stages = 7;

  logic [Stages-1:0] v_q;

  logic [SumW-1:0]  neg_sum_c;
  logic [38:0]      est_c;
  logic [37:0]      qm_c;
  logic [20:0]      r2_c;
  logic signed [19:0] ang_c, wrap_c;
  logic signed [AngW-1:0] z0_c;
  rot_t             rot_c;

  // Magnitude and sign
  logic             a1_neg_q;
  logic [SumW-2:0]  a1_u_q;
  vec_t             a1_vec_q;
  // First fold below 2^37
  logic             a2_neg_q;
  logic [36:0]      a2_u_q;
  vec_t             a2_vec_q;
  // Quotient estimate
  logic             a3_neg_q;
  logic [36:0]      a3_u_q;
  logic [18:0]      a3_q_q;
  vec_t             a3_vec_q;
  // Remainder below three turns
  logic             a4_neg_q;
  logic [20:0]      a4_r_q;
  vec_t             a4_vec_q;
  // Signed remainder
  logic signed [19:0] a5_ang_q;
  vec_t             a5_vec_q;
  // Wrapped to [-pi, pi]
  logic signed [19:0] a6_ang_q;
  vec_t             a6_vec_q;
  rot_t             a7_q;

  assign neg_sum_c = SumW'(-data_i.ang_sum);
  assign est_c     = 39'(a2_u_q[36:18]) * 39'(Recip);
  assign qm_c      = 38'(a3_q_q) * 38'(TwoPiQ16);

  // Remainder correction, at most two turns too many
  always_comb begin
    if (a4_r_q >= 21'(TwoPiQ16) + 21'(TwoPiQ16)) begin
      r2_c = a4_r_q - 21'(TwoPiQ16) - 21'(TwoPiQ16);
    end else if (a4_r_q >= 21'(TwoPiQ16)) begin
      r2_c = a4_r_q - 21'(TwoPiQ16);
    end else begin
      r2_c = a4_r_q;
    end
    ang_c = a4_neg_q ? -$signed(20'(r2_c)) : $signed(20'(r2_c));
  end

  // Wrap into [-pi, pi]
  always_comb begin
    if (a5_ang_q > $signed(20'(PiQ16))) begin
      wrap_c = a5_ang_q - $signed(20'(TwoPiQ16));
    end else if (a5_ang_q < -$signed(20'(PiQ16))) begin
      wrap_c = a5_ang_q + $signed(20'(TwoPiQ16));
    end else begin
      wrap_c = a5_ang_q;
    end
  end

  // Q2.30 angle and half-turn fold with vector negation
  always_comb begin
    z0_c = AngW'(a6_ang_q) <<< 14;
    rot_c.vec = a6_vec_q;
    if (z0_c > HalfPiQ30) begin
      rot_c.z     = z0_c - PiQ30;
      rot_c.vec.x = -a6_vec_q.x;
      rot_c.vec.y = -a6_vec_q.y;
    end else if (z0_c < -HalfPiQ30) begin
      rot_c.z     = z0_c + PiQ30;
      rot_c.vec.x = -a6_vec_q.x;
      rot_c.vec.y = -a6_vec_q.y;
    end else begin
      rot_c.z = z0_c;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[Stages-2:0], valid_i};
    end
  end

  // Payload stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_neg_q <= data_i.ang_sum[SumW-1];
      a1_u_q   <= data_i.ang_sum[SumW-1] ? neg_sum_c[SumW-2:0]
                                         : data_i.ang_sum[SumW-2:0];
      a1_vec_q <= data_i.vec;

      a2_neg_q <= a1_neg_q;
      a2_u_q   <= 37'(a1_u_q[SumW-2:34]) * 37'(Fold34) + 37'(a1_u_q[33:0]);
      a2_vec_q <= a1_vec_q;

      a3_neg_q <= a2_neg_q;
      a3_u_q   <= a2_u_q;
      a3_q_q   <= est_c[38:20];
      a3_vec_q <= a2_vec_q;

      a4_neg_q <= a3_neg_q;
      a4_r_q   <= 21'(38'(a3_u_q) - qm_c);
      a4_vec_q <= a3_vec_q;

      a5_ang_q <= ang_c;
      a5_vec_q <= a4_vec_q;

      a6_ang_q <= wrap_c;
      a6_vec_q <= a5_vec_q;

      a7_q <= rot_c;
    end
  end

  assign valid_o = v_q[Stages-1];
  assign data_o  = a7_q;

endmodule

[rtl/bfp_cordic.sv]
// Unrolled CORDIC rotation, one register stage per iteration.
// Depends on bfp_pkg.
`timescale 1ns / 1ps

module bfp_cordic #(
  parameter int unsigned CORDIC_STEPS = bfp_pkg::DefCordicSteps
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  bfp_pkg::rot_t data_i,
  output logic          valid_o,
  output bfp_pkg::vec_t data_o
);
  import bfp_pkg::*;

  localparam int unsigned NSteps =
    (CORDIC_STEPS > MaxCordicSteps) ? MaxCordicSteps : CORDIC_STEPS;

  logic [NSteps-1:0] v_q;
  rot_t              pipe_in [NSteps+1];
  rot_t              pipe_q  [NSteps];

  assign pipe_in[0] = data_i;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NSteps-2:0], valid_i};
    end
  end

  for (genvar i = 0; i < NSteps; i++) begin : g_iter
    rot_t nxt_d;
    logic signed [VecW-1:0] xs, ys;
    logic signed [AngW-1:0] atan_s;

    assign xs     = pipe_in[i].vec.x >>> i;
    assign ys     = pipe_in[i].vec.y >>> i;
    assign atan_s = $signed(AngW'(AtanQ30[i]));

    // Rotate towards zero residual angle
    always_comb begin
      nxt_d = pipe_in[i];
      if (!pipe_in[i].z[AngW-1]) begin
        nxt_d.vec.x = pipe_in[i].vec.x - ys;
        nxt_d.vec.y = pipe_in[i].vec.y + xs;
        nxt_d.z     = pipe_in[i].z - atan_s;
      end else begin
        nxt_d.vec.x = pipe_in[i].vec.x + ys;
        nxt_d.vec.y = pipe_in[i].vec.y - xs;
        nxt_d.z     = pipe_in[i].z + atan_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pipe_q[i] <= nxt_d;
      end
    end

    assign pipe_in[i+1] = pipe_q[i];
  end

  assign valid_o = v_q[NSteps-1];
  assign data_o  = pipe_in[NSteps].vec;

endmodule
